@@ sv/dq_pkg.sv @@
// Package for the double-ended queue: beat structs, operation codes and status codes.
// Used by dq_ctrl, dq_datapath and the double_ended_queue top level.
// No dependencies.
package dq_pkg;

	localparam int FUNC_W   = 2;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 7;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_PUSH_A = 2'd0,
		FUNC_PUSH_B = 2'd1,
		FUNC_POP_A  = 2'd2,
		FUNC_POP_B  = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [VALUE_W-1:0] value;
	} op_beat_t;

	typedef struct packed {
		logic [VALUE_W-1:0]  popped_word;
		logic [STATUS_W-1:0] status;
		logic [OCC_W-1:0]    occupancy;
	} res_beat_t;

	// Command from the controller to the datapath.
	typedef struct packed {
		logic load;
	} dq_cmd_t;

endpackage

@@ sv/dq_ctrl.sv @@
// Controller for the double-ended queue: sequences one operation beat at a time.
// Depends on dq_pkg.
module dq_ctrl
	import dq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    op_valid,
	output logic    op_stall,
	output logic    res_valid,
	input  logic    res_stall,
	output dq_cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_RESP
	} state_t;

	state_t state_q;
	logic   res_valid_q;

	assign op_stall  = (state_q != ST_IDLE);
	assign cmd.load  = op_valid && (state_q == ST_IDLE);
	assign res_valid = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (op_valid) begin
						state_q     <= ST_RESP;
						res_valid_q <= 1'b1;
					end
				end
				ST_RESP: begin
					if (!res_stall) begin
						state_q     <= ST_IDLE;
						res_valid_q <= 1'b0;
					end
				end
				default: begin
					state_q     <= ST_IDLE;
					res_valid_q <= 1'b0;
				end
			endcase
		end
	end

	// Every accepted operation produces a result beat in the next cycle.
	a_load_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> res_valid)
		else $error("accepted operation did not raise a result");

	// No new operation is taken while a result is pending.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !cmd.load)
		else $error("operation accepted while a result is pending");

	// A stalled result beat stays offered.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> res_valid)
		else $error("result beat dropped while stalled");

endmodule

@@ sv/dq_datapath.sv @@
// Datapath for the double-ended queue: ring store, end pointers, count and result registers.
// Depends on dq_pkg; driven by dq_ctrl through dq_cmd_t.
module dq_datapath
	import dq_pkg::*;
#(
	parameter int DEPTH      = 64,
	parameter int WORD_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  dq_cmd_t   cmd,
	input  op_beat_t  op,
	output res_beat_t res
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WORD_WIDTH-1:0] store_q [DEPTH];
	logic [WORD_WIDTH-1:0] rd_q;
	logic [PW-1:0]         a_ptr_q;
	logic [PW-1:0]         b_ptr_q;
	logic [CW-1:0]         count_q;
	logic [STATUS_W-1:0]   status_q;
	logic                  pop_ok_q;

	logic [PW-1:0] a_next, a_prev, b_next, b_prev;
	logic          full, empty;
	logic          wr_en, rd_en;
	logic [PW-1:0] wr_addr, rd_addr;
	logic [63:0]   rd_wide;

	assign a_next = (a_ptr_q == PW'(DEPTH - 1)) ? '0 : a_ptr_q + PW'(1);
	assign a_prev = (a_ptr_q == '0) ? PW'(DEPTH - 1) : a_ptr_q - PW'(1);
	assign b_next = (b_ptr_q == PW'(DEPTH - 1)) ? '0 : b_ptr_q + PW'(1);
	assign b_prev = (b_ptr_q == '0) ? PW'(DEPTH - 1) : b_ptr_q - PW'(1);
	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);

	always_comb begin
		wr_en   = 1'b0;
		rd_en   = 1'b0;
		wr_addr = a_ptr_q;
		rd_addr = b_ptr_q;
		unique case (func_t'(op.func))
			FUNC_PUSH_A: begin
				wr_en   = cmd.load && !full;
				wr_addr = a_ptr_q;
			end
			FUNC_PUSH_B: begin
				wr_en   = cmd.load && !full;
				wr_addr = b_prev;
			end
			FUNC_POP_A: begin
				rd_en   = cmd.load && !empty;
				rd_addr = a_prev;
			end
			FUNC_POP_B: begin
				rd_en   = cmd.load && !empty;
				rd_addr = b_ptr_q;
			end
			default: begin
				wr_en = 1'b0;
				rd_en = 1'b0;
			end
		endcase
	end

	// Ring store: one write or one registered read per operation.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_addr] <= WORD_WIDTH'(op.value);
		end
		if (rd_en) begin
			rd_q <= store_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_ptr_q  <= '0;
			b_ptr_q  <= '0;
			count_q  <= '0;
			status_q <= STATUS_OK;
			pop_ok_q <= 1'b0;
		end else if (cmd.load) begin
			status_q <= STATUS_OK;
			pop_ok_q <= 1'b0;
			unique case (func_t'(op.func))
				FUNC_PUSH_A: begin
					if (full) begin
						status_q <= STATUS_FULL;
					end else begin
						a_ptr_q <= a_next;
						count_q <= count_q + CW'(1);
					end
				end
				FUNC_PUSH_B: begin
					if (full) begin
						status_q <= STATUS_FULL;
					end else begin
						b_ptr_q <= b_prev;
						count_q <= count_q + CW'(1);
					end
				end
				FUNC_POP_A: begin
					if (empty) begin
						status_q <= STATUS_EMPTY;
					end else begin
						a_ptr_q  <= a_prev;
						count_q  <= count_q - CW'(1);
						pop_ok_q <= 1'b1;
					end
				end
				FUNC_POP_B: begin
					if (empty) begin
						status_q <= STATUS_EMPTY;
					end else begin
						b_ptr_q  <= b_next;
						count_q  <= count_q - CW'(1);
						pop_ok_q <= 1'b1;
					end
				end
				default: begin
					status_q <= STATUS_OK;
				end
			endcase
		end
	end

	assign rd_wide         = 64'(rd_q);
	assign res.popped_word = pop_ok_q ? rd_wide[VALUE_W-1:0] : '0;
	assign res.status      = status_q;
	assign res.occupancy   = OCC_W'(count_q);

	// The end-A pointer always sits count slots past the end-B pointer around the ring.
	logic [CW:0] b_plus_count;
	logic [CW:0] b_plus_count_wrapped;
	assign b_plus_count         = (CW + 1)'(b_ptr_q) + (CW + 1)'(count_q);
	assign b_plus_count_wrapped = (b_plus_count >= (CW + 1)'(DEPTH))
		? b_plus_count - (CW + 1)'(DEPTH) : b_plus_count;

	a_ptr_relation: assert property (@(posedge clk) disable iff (!arst_n)
		(CW + 1)'(a_ptr_q) == b_plus_count_wrapped)
		else $error("end pointers disagree with word count");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("word count exceeds depth");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(status_q == STATUS_FULL) |-> full)
		else $error("full status reported while store has room");

endmodule

@@ sv/double_ended_queue.sv @@
// A result beat appears the cycle after its operation beat is accepted.
// The block takes no new operation until the last result beat has been taken;
// the store takes one beat at a time and reads through a registered port.
// Reset (arst_n, asynchronous, active low) empties the queue: both end pointers
// and the word count go to zero; store contents are left as they are.
// Depends on dq_pkg, dq_ctrl and dq_datapath.
module double_ended_queue
	import dq_pkg::*;
#(
	parameter int DEPTH      = 64,
	parameter int WORD_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      op_valid,
	output logic      op_stall,
	input  op_beat_t  op,
	output logic      res_valid,
	input  logic      res_stall,
	output res_beat_t res
);

	// The controller owns the handshake on both channels. It takes one operation
	// beat while idle, then holds the result beat until the downstream side takes it.
	dq_cmd_t cmd;

	dq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op_stall  (op_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.cmd       (cmd)
	);

	// The datapath acts in the accepting cycle: a push with room or a pop with
	// data moves one pointer, updates the count and writes the store or launches
	// a read. Its result registers and the registered read data stay put while
	// the result beat waits, since no new operation is taken until then.
	dq_datapath #(
		.DEPTH      (DEPTH),
		.WORD_WIDTH (WORD_WIDTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.op     (op),
		.res    (res)
	);

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for double_ended_queue: a short table of directed beats, then
// random bursts, every result checked against a typed value or a ring-store deque model.
// Depends on dq_pkg and the double_ended_queue RTL.
module testbench;
	import dq_pkg::*;

	localparam int QUEUE_DEPTH = 64;
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int RANDOM_OPS = 2000;
	// The longest correct gap with no beat moving is set by the receiver hold-off;
	// the limit leaves a wide margin over that.
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 20;
	// The hold-off starts once this many results have been taken.
	localparam int HOLD_OFF_AFTER = 400;
	// Slots in the ring of expected results; far more than can ever be outstanding.
	localparam int EXPECT_SLOTS = 16;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic op_valid = 1'b0;
	logic op_stall;
	op_beat_t op = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_beat_t res;

	double_ended_queue #(.DEPTH(QUEUE_DEPTH), .WORD_WIDTH(VALUE_W)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op_stall (op_stall),
		.op       (op),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	always #5 clk = ~clk;

	// One row of the directed table. A row is sent count times, the value stepping by
	// one each time. Where has_result is set, the expected result is the one typed in
	// the row; otherwise it comes from the deque model.
	typedef struct packed {
		func_t             row_func;
		logic [VALUE_W-1:0] first_value;
		logic [7:0]        count;
		logic              has_result;
		res_beat_t         typed_result;
	} dir_row_t;

	localparam res_beat_t FROM_MODEL = '0;

	dir_row_t directed_rows [22] = '{
		// Pops on an empty queue after reset, at both ends.
		'{FUNC_POP_A,  32'h0000_0000, 8'd1,  1'b1, '{32'h0000_0000, STATUS_EMPTY, 7'd0}},
		'{FUNC_POP_B,  32'hFFFF_FFFF, 8'd1,  1'b1, '{32'h0000_0000, STATUS_EMPTY, 7'd0}},
		// Extreme words through both ends; the push at end B wraps its pointer below zero.
		'{FUNC_PUSH_A, 32'hFFFF_FFFF, 8'd1,  1'b1, '{32'h0000_0000, STATUS_OK,    7'd1}},
		'{FUNC_PUSH_B, 32'h0000_0000, 8'd1,  1'b1, '{32'h0000_0000, STATUS_OK,    7'd2}},
		'{FUNC_POP_A,  32'h0000_0000, 8'd1,  1'b1, '{32'hFFFF_FFFF, STATUS_OK,    7'd1}},
		'{FUNC_POP_B,  32'hFFFF_FFFF, 8'd1,  1'b1, '{32'h0000_0000, STATUS_OK,    7'd0}},
		'{FUNC_POP_A,  32'h1234_5678, 8'd1,  1'b1, '{32'h0000_0000, STATUS_EMPTY, 7'd0}},
		// Mixed pushes, then alternating pops that take back each end's own words.
		'{FUNC_PUSH_A, 32'hAAAA_AAAA, 8'd1,  1'b0, FROM_MODEL},
		'{FUNC_PUSH_A, 32'h5555_5555, 8'd1,  1'b0, FROM_MODEL},
		'{FUNC_PUSH_B, 32'h8000_0000, 8'd1,  1'b0, FROM_MODEL},
		'{FUNC_PUSH_B, 32'h0000_0001, 8'd1,  1'b0, FROM_MODEL},
		'{FUNC_POP_B,  32'h0000_0000, 8'd1,  1'b0, FROM_MODEL},
		'{FUNC_POP_A,  32'h0000_0000, 8'd1,  1'b0, FROM_MODEL},
		'{FUNC_POP_B,  32'h0000_0000, 8'd1,  1'b0, FROM_MODEL},
		'{FUNC_POP_A,  32'h0000_0000, 8'd1,  1'b0, FROM_MODEL},
		'{FUNC_POP_A,  32'h0000_0000, 8'd1,  1'b1, '{32'h0000_0000, STATUS_EMPTY, 7'd0}},
		// Fill the store completely, then push at both ends while full.
		'{FUNC_PUSH_B, 32'h1000_0000, 8'd64, 1'b0, FROM_MODEL},
		'{FUNC_PUSH_A, 32'hDEAD_BEEF, 8'd1,  1'b1, '{32'h0000_0000, STATUS_FULL,  7'd64}},
		'{FUNC_PUSH_B, 32'h7FFF_FFFF, 8'd1,  1'b1, '{32'h0000_0000, STATUS_FULL,  7'd64}},
		// Drain from both ends until empty, then one more pop.
		'{FUNC_POP_A,  32'h0000_0000, 8'd32, 1'b0, FROM_MODEL},
		'{FUNC_POP_B,  32'h0000_0000, 8'd32, 1'b0, FROM_MODEL},
		'{FUNC_POP_B,  32'h0000_0000, 8'd1,  1'b1, '{32'h0000_0000, STATUS_EMPTY, 7'd0}}
	};

	// Deque model: a ring of words with one pointer per end. end_a_slot is one past
	// the end-A word, end_b_slot is the end-B word itself, and the ring wraps by
	// pointer overflow since the depth is a power of two.
	logic [VALUE_W-1:0] ring_words [QUEUE_DEPTH];
	logic [PTR_W-1:0] end_a_slot = '0;
	logic [PTR_W-1:0] end_b_slot = '0;
	logic [OCC_W-1:0] words_held = '0;

	// Expected results in order, kept in a small ring with running head and tail counts.
	res_beat_t expected_results [EXPECT_SLOTS];
	int expect_head = 0;
	int expect_tail = 0;
	int errors = 0;
	int results_seen = 0;
	int idle_cycles = 0;

	// Set by the sender during a stretch of the random part in which neither side idles.
	bit calm = 1'b0;
	bit hold_off_done = 1'b0;

	// Alongside each payload the sender states whether a typed result goes with it.
	logic given_check = 1'b0;
	res_beat_t given_result = '0;

	// Performs one operation on the model and returns the result it gives.
	function automatic res_beat_t deque_apply(input op_beat_t beat);
		res_beat_t outcome;
		outcome = '0;
		case (func_t'(beat.func))
			FUNC_PUSH_A: begin
				if (words_held == QUEUE_DEPTH) begin
					outcome.status = STATUS_FULL;
				end else begin
					ring_words[end_a_slot] = beat.value;
					end_a_slot++;
					words_held++;
				end
			end
			FUNC_PUSH_B: begin
				if (words_held == QUEUE_DEPTH) begin
					outcome.status = STATUS_FULL;
				end else begin
					end_b_slot--;
					ring_words[end_b_slot] = beat.value;
					words_held++;
				end
			end
			FUNC_POP_A: begin
				if (words_held == 0) begin
					outcome.status = STATUS_EMPTY;
				end else begin
					end_a_slot--;
					outcome.popped_word = ring_words[end_a_slot];
					words_held--;
				end
			end
			default: begin
				if (words_held == 0) begin
					outcome.status = STATUS_EMPTY;
				end else begin
					outcome.popped_word = ring_words[end_b_slot];
					end_b_slot++;
					words_held--;
				end
			end
		endcase
		outcome.occupancy = words_held;
		return outcome;
	endfunction

	// Offers one operation beat from a falling edge and returns at the falling edge
	// after it is taken. Valid stays high into the next call, so back-to-back beats
	// never drop it; an idle gap lowers it first, at an earlier time step.
	task automatic send_op(input func_t f, input logic [VALUE_W-1:0] v,
			input logic check, input res_beat_t result);
		while (!calm && $urandom_range(99) < 9) begin
			op_valid <= 1'b0;
			@(negedge clk);
		end
		op_valid <= 1'b1;
		op <= '{func: f, value: v};
		given_check <= check;
		given_result <= result;
		@(posedge clk);
		while (op_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// Both handshakes are observed at the rising edge. The operation side goes first so
	// that an expectation is in place before any result it causes could be taken.
	always @(posedge clk) begin
		res_beat_t want;
		res_beat_t from_model;
		logic moved;
		moved = 1'b0;
		if (arst_n && op_valid && !op_stall) begin
			moved = 1'b1;
			from_model = deque_apply(op);
			want = given_check ? given_result : from_model;
			expected_results[expect_tail % EXPECT_SLOTS] = want;
			expect_tail++;
		end
		if (arst_n && res_valid && !res_stall) begin
			moved = 1'b1;
			results_seen++;
			if (expect_tail == expect_head) begin
				$display("%0t: result beat with none expected: %h", $time, res);
				errors++;
			end else begin
				want = expected_results[expect_head % EXPECT_SLOTS];
				expect_head++;
				if (res.popped_word !== want.popped_word) begin
					$display("%0t: popped_word expected %h, got %h",
						$time, want.popped_word, res.popped_word);
					errors++;
				end
				if (res.status !== want.status) begin
					$display("%0t: status expected %0d, got %0d", $time, want.status, res.status);
					errors++;
				end
				if (res.occupancy !== want.occupancy) begin
					$display("%0t: occupancy expected %0d, got %0d",
						$time, want.occupancy, res.occupancy);
					errors++;
				end
			end
		end
		idle_cycles = moved ? 0 : idle_cycles + 1;
	end

	// Watchdog: ends the run once no beat has moved on either side for too long.
	initial begin
		while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("CHECKS FAILED");
		$finish;
	end

	// Result side: stalls at random, except during the calm stretch. Once, it holds
	// stall high for a long stretch while the sender keeps offering, so the block
	// backs up and has to stall its operation input.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_off_done && results_seen >= HOLD_OFF_AFTER) begin
				hold_off_done = 1'b1;
				res_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end
			res_stall <= !calm && ($urandom_range(99) < 9);
		end
	end

	initial begin
		int sent;
		int burst;
		int push_pct;
		func_t f;
		logic [VALUE_W-1:0] v;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[r]) begin
			for (int k = 0; k < directed_rows[r].count; k++) begin
				send_op(directed_rows[r].row_func, directed_rows[r].first_value + k,
					directed_rows[r].has_result, directed_rows[r].typed_result);
			end
		end

		// Random bursts, each leaning toward filling, draining or neither, so that the
		// queue keeps crossing between empty and full and both pointers wrap often.
		sent = 0;
		while (sent < RANDOM_OPS) begin
			case ($urandom_range(2))
				0: push_pct = 85;
				1: push_pct = 15;
				default: push_pct = 50;
			endcase
			burst = $urandom_range(120, 20);
			for (int i = 0; i < burst && sent < RANDOM_OPS; i++) begin
				calm = (sent >= 800 && sent < 1100);
				if ($urandom_range(99) < push_pct) begin
					f = $urandom_range(1) ? FUNC_PUSH_B : FUNC_PUSH_A;
				end else begin
					f = $urandom_range(1) ? FUNC_POP_B : FUNC_POP_A;
				end
				case ($urandom_range(9))
					0: v = '0;
					1: v = '1;
					default: v = $urandom;
				endcase
				send_op(f, v, 1'b0, FROM_MODEL);
				sent++;
			end
		end
		calm = 1'b0;
		op_valid <= 1'b0;

		// Wait out every outstanding result, then a drain period for strays.
		while (expect_tail != expect_head) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

@@ files.f @@
sv/dq_pkg.sv
sv/dq_ctrl.sv
sv/dq_datapath.sv
sv/double_ended_queue.sv
test/testbench.sv
